// ===== hw/rtl/msvf_pkg.sv =====
// Shared types and constants of the multimode filter
package msvf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP_GAIN   = 3'd7;

  // Filter modes
  localparam logic [2:0] MODE_LOWPASS  = 3'd0;
  localparam logic [2:0] MODE_BANDPASS = 3'd1;
  localparam logic [2:0] MODE_HIGHPASS = 3'd2;
  localparam logic [2:0] MODE_NOTCH    = 3'd3;
  localparam logic [2:0] MODE_LADDER   = 3'd4;

  // Reset values of the registers
  localparam logic [17:0] RST_COEF_A1       = 18'd55803;
  localparam logic [17:0] RST_COEF_A2       = 18'd6388;
  localparam logic [17:0] RST_COEF_A3       = 18'd731;
  localparam logic [17:0] RST_DAMPING       = 18'd92340;
  localparam logic [15:0] RST_STAGE_GAIN    = 16'd26730;
  localparam logic [18:0] RST_FEEDBACK_GAIN = 19'd137626;
  localparam logic [17:0] RST_MAKEUP_GAIN   = 18'd96993;

  // Arithmetic formats
  localparam int COEF_FRAC = 16;
  localparam int MUL_B_W   = 20;
  localparam int TANH_FRAC = 15;
  localparam int EXP_FRAC  = 30;

  typedef struct packed {
    logic [2:0]  filter_mode;
    logic [17:0] coef_a1;
    logic [17:0] coef_a2;
    logic [17:0] coef_a3;
    logic [17:0] damping;
    logic [15:0] stage_gain;
    logic [18:0] feedback_gain;
    logic [17:0] makeup_gain;
  } cfg_t;

  // Datapath operations, one per cycle while the sequencer is not waiting on the output
  typedef enum logic [4:0] {
    OP_NONE,
    OP_SVF_V3,
    OP_SVF_M2,
    OP_SVF_V1,
    OP_SVF_M4,
    OP_SVF_V2,
    OP_SVF_N1,
    OP_TANH_LOOK,
    OP_TANH_MUL,
    OP_TANH_DONE,
    OP_SVF_END,
    OP_LAD_FB,
    OP_LAD_FBSAT,
    OP_LAD_IN,
    OP_LAD_MUL,
    OP_LAD_ACC,
    OP_LAD_MAKEUP,
    OP_LAD_END,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic       load;
    op_e        op;
    logic [1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/msvf_cfg.sv =====
// Configuration register file of the multimode filter
module msvf_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [msvf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [msvf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output msvf_pkg::cfg_t                    cfg_o
);

  msvf_pkg::cfg_t cfg_q;

  // Write one register per word; an unknown mode falls back to lowpass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode   <= msvf_pkg::MODE_LOWPASS;
      cfg_q.coef_a1       <= msvf_pkg::RST_COEF_A1;
      cfg_q.coef_a2       <= msvf_pkg::RST_COEF_A2;
      cfg_q.coef_a3       <= msvf_pkg::RST_COEF_A3;
      cfg_q.damping       <= msvf_pkg::RST_DAMPING;
      cfg_q.stage_gain    <= msvf_pkg::RST_STAGE_GAIN;
      cfg_q.feedback_gain <= msvf_pkg::RST_FEEDBACK_GAIN;
      cfg_q.makeup_gain   <= msvf_pkg::RST_MAKEUP_GAIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        msvf_pkg::REG_FILTER_MODE: begin
          if (cfg_data_i[2:0] > msvf_pkg::MODE_LADDER) begin
            cfg_q.filter_mode <= msvf_pkg::MODE_LOWPASS;
          end else begin
            cfg_q.filter_mode <= cfg_data_i[2:0];
          end
        end
        msvf_pkg::REG_COEF_A1:       cfg_q.coef_a1       <= cfg_data_i[17:0];
        msvf_pkg::REG_COEF_A2:       cfg_q.coef_a2       <= cfg_data_i[17:0];
        msvf_pkg::REG_COEF_A3:       cfg_q.coef_a3       <= cfg_data_i[17:0];
        msvf_pkg::REG_DAMPING:       cfg_q.damping       <= cfg_data_i[17:0];
        msvf_pkg::REG_STAGE_GAIN:    cfg_q.stage_gain    <= cfg_data_i[15:0];
        msvf_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_data_i[18:0];
        msvf_pkg::REG_MAKEUP_GAIN:   cfg_q.makeup_gain   <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/msvf_ctrl.sv =====
// Sequencer of the multimode filter: steps the datapath through one word
module msvf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        filter_mode_i,
  input  msvf_pkg::sts_t    sts_i,
  output msvf_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SVF_V3,
    ST_SVF_M2,
    ST_SVF_V1,
    ST_SVF_M4,
    ST_SVF_V2,
    ST_SVF_N1,
    ST_TANH_LOOK,
    ST_TANH_MUL,
    ST_TANH_DONE,
    ST_SVF_END,
    ST_LAD_FB,
    ST_LAD_FBSAT,
    ST_LAD_IN,
    ST_LAD_MUL,
    ST_LAD_ACC,
    ST_LAD_MAKEUP,
    ST_LAD_END,
    ST_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] stage_q;
  logic       ladder;

  assign ladder     = (filter_mode_i == msvf_pkg::MODE_LADDER);
  assign in_ready_o = (state_q == ST_IDLE);

  // Advance state and ladder stage counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= 2'd0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ladder ? ST_LAD_FB : ST_SVF_V3;
          end
        end
        ST_SVF_V3:    state_q <= ST_SVF_M2;
        ST_SVF_M2:    state_q <= ST_SVF_V1;
        ST_SVF_V1:    state_q <= ST_SVF_M4;
        ST_SVF_M4:    state_q <= ST_SVF_V2;
        ST_SVF_V2:    state_q <= ST_SVF_N1;
        ST_SVF_N1:    state_q <= ST_TANH_LOOK;
        ST_TANH_LOOK: state_q <= ST_TANH_MUL;
        ST_TANH_MUL:  state_q <= ST_TANH_DONE;
        ST_TANH_DONE: state_q <= ladder ? ST_LAD_IN : ST_SVF_END;
        ST_SVF_END:   state_q <= ST_OUT;
        ST_LAD_FB:    state_q <= ST_LAD_FBSAT;
        ST_LAD_FBSAT: state_q <= ST_TANH_LOOK;
        ST_LAD_IN: begin
          state_q <= ST_LAD_MUL;
          stage_q <= 2'd0;
        end
        ST_LAD_MUL:   state_q <= ST_LAD_ACC;
        ST_LAD_ACC: begin
          stage_q <= stage_q + 2'd1;
          state_q <= (stage_q == 2'd3) ? ST_LAD_MAKEUP : ST_LAD_MUL;
        end
        ST_LAD_MAKEUP: state_q <= ST_LAD_END;
        ST_LAD_END:    state_q <= ST_OUT;
        ST_OUT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Decode the operation of the current step
  always_comb begin
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.stage = stage_q;
    unique case (state_q)
      ST_SVF_V3:     cmd_o.op = msvf_pkg::OP_SVF_V3;
      ST_SVF_M2:     cmd_o.op = msvf_pkg::OP_SVF_M2;
      ST_SVF_V1:     cmd_o.op = msvf_pkg::OP_SVF_V1;
      ST_SVF_M4:     cmd_o.op = msvf_pkg::OP_SVF_M4;
      ST_SVF_V2:     cmd_o.op = msvf_pkg::OP_SVF_V2;
      ST_SVF_N1:     cmd_o.op = msvf_pkg::OP_SVF_N1;
      ST_TANH_LOOK:  cmd_o.op = msvf_pkg::OP_TANH_LOOK;
      ST_TANH_MUL:   cmd_o.op = msvf_pkg::OP_TANH_MUL;
      ST_TANH_DONE:  cmd_o.op = msvf_pkg::OP_TANH_DONE;
      ST_SVF_END:    cmd_o.op = msvf_pkg::OP_SVF_END;
      ST_LAD_FB:     cmd_o.op = msvf_pkg::OP_LAD_FB;
      ST_LAD_FBSAT:  cmd_o.op = msvf_pkg::OP_LAD_FBSAT;
      ST_LAD_IN:     cmd_o.op = msvf_pkg::OP_LAD_IN;
      ST_LAD_MUL:    cmd_o.op = msvf_pkg::OP_LAD_MUL;
      ST_LAD_ACC:    cmd_o.op = msvf_pkg::OP_LAD_ACC;
      ST_LAD_MAKEUP: cmd_o.op = msvf_pkg::OP_LAD_MAKEUP;
      ST_LAD_END:    cmd_o.op = msvf_pkg::OP_LAD_END;
      ST_OUT:        cmd_o.op = sts_i.out_free ? msvf_pkg::OP_OUT : msvf_pkg::OP_NONE;
      default:       cmd_o.op = msvf_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/msvf_dp.sv =====
// Datapath of the multimode filter: state, shared multiplier, tanh table
module msvf_dp #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int STATE_WIDTH      = 32,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msvf_pkg::cmd_t                 cmd_i,
  input  msvf_pkg::cfg_t                 cfg_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output msvf_pkg::sts_t                 sts_o
);

  localparam int SW     = STATE_WIDTH;
  localparam int SAW    = SAMPLE_WIDTH;
  localparam int Frac   = SW - 8;
  localparam int CW     = msvf_pkg::MUL_B_W;
  localparam int PW     = SW + 1 + CW;
  localparam int WW     = SW + 24;
  localparam int YW     = SW + 2;
  localparam int Ld     = $clog2(TANH_TABLE_DEPTH);
  localparam int ShS    = Frac - (SAW - 1);
  localparam int ShPos  = (ShS > 0) ? ShS : 0;
  localparam int ShNeg  = (ShS < 0) ? -ShS : 0;
  localparam int XW     = SW + 1;
  localparam int FW     = YW + 1 + ShNeg;
  localparam int IdxW   = Ld + 6;

  localparam logic signed [WW-1:0] SMax  = WW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] SMin  = -SMax - WW'(1);
  localparam logic signed [WW-1:0] RndC  = WW'(64'sd1 <<< (msvf_pkg::COEF_FRAC - 1));
  localparam logic signed [WW-1:0] RndF  = WW'(64'sd1 <<< (Frac - 1));
  localparam logic signed [XW-1:0] RndIn =
    XW'((ShNeg > 0) ? (64'sd1 <<< ((ShNeg > 0) ? ShNeg - 1 : 0)) : 64'sd0);
  localparam logic signed [FW-1:0] RndOut =
    FW'((ShPos > 0) ? (64'sd1 <<< ((ShPos > 0) ? ShPos - 1 : 0)) : 64'sd0);
  localparam logic signed [FW-1:0] OutMax = FW'((64'sd1 <<< (SAW - 1)) - 64'sd1);
  localparam logic signed [FW-1:0] OutMin = -OutMax - FW'(1);

  typedef logic [15:0] rom_t [TANH_TABLE_DEPTH+1];

  // Unsigned quotient by shift and subtract, used only while building the table
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4*i/DEPTH) in Q0.15 from an exp(-u) series squared four times
  function automatic longint unsigned tanh_point(input int unsigned i);
    longint unsigned one;
    longint unsigned u;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned num;
    longint unsigned den;
    one  = 64'd1 << msvf_pkg::EXP_FRAC;
    u    = (64'(i) << msvf_pkg::EXP_FRAC) >> (Ld + 1);
    sum  = one;
    term = one;
    for (int n = 1; n <= 12; n++) begin
      term = udiv((term * u) >> msvf_pkg::EXP_FRAC, 64'(n));
      if ((n & 1) == 1) sum = sum - term;
      else              sum = sum + term;
    end
    for (int n = 0; n < 4; n++) begin
      sum = (sum * sum + (one >> 1)) >> msvf_pkg::EXP_FRAC;
    end
    if (sum > one) sum = one;
    num = one - sum;
    den = one + sum;
    return udiv((num << msvf_pkg::TANH_FRAC) + (den >> 1), den);
  endfunction

  // Table entries, the end value sits one past the last entry
  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      r[i] = 16'(tanh_point(i));
    end
    return r;
  endfunction

  localparam rom_t TanhRom = build_rom();

  function automatic logic signed [SW-1:0] sat(input logic signed [WW-1:0] v);
    if (v > SMax)      return SMax[SW-1:0];
    else if (v < SMin) return SMin[SW-1:0];
    else               return v[SW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] rnd_coef(input logic signed [WW-1:0] v);
    return (v + RndC) >>> msvf_pkg::COEF_FRAC;
  endfunction

  // State and working registers
  logic signed [SW-1:0]  ic1_q, ic2_q;
  logic signed [SW-1:0]  stg_q [4];
  logic signed [SW-1:0]  x_q, v1_q, v2_q, v3_q, mk_q, t_q, th_q, prev_q;
  logic signed [WW-1:0]  acc_q;
  logic signed [PW-1:0]  prod_q;
  logic        [15:0]    lo_q, hi_q;
  logic        [Frac-1:0] fr_q;
  logic                  neg_q;
  logic signed [YW-1:0]  y_q;
  logic signed [SAW-1:0] sample_out_q;
  logic                  out_valid_q;

  // Shared multiplier operands
  logic signed [SW:0]    mul_a;
  logic signed [CW-1:0]  mul_b;
  logic signed [PW-1:0]  prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      msvf_pkg::OP_SVF_V3: begin
        mul_a = (SW+1)'(ic1_q);
        mul_b = CW'(cfg_i.coef_a1);
      end
      msvf_pkg::OP_SVF_M2: begin
        mul_a = (SW+1)'(v3_q);
        mul_b = CW'(cfg_i.coef_a2);
      end
      msvf_pkg::OP_SVF_V1: begin
        mul_a = (SW+1)'(ic1_q);
        mul_b = CW'(cfg_i.coef_a2);
      end
      msvf_pkg::OP_SVF_M4: begin
        mul_a = (SW+1)'(v3_q);
        mul_b = CW'(cfg_i.coef_a3);
      end
      msvf_pkg::OP_SVF_V2: begin
        mul_a = (SW+1)'(v1_q);
        mul_b = CW'(cfg_i.damping);
      end
      msvf_pkg::OP_TANH_MUL: begin
        mul_a = (SW+1)'(fr_q);
        mul_b = CW'(signed'({1'b0, hi_q}) - signed'({1'b0, lo_q}));
      end
      msvf_pkg::OP_LAD_FB: begin
        mul_a = (SW+1)'(stg_q[3]);
        mul_b = CW'(cfg_i.feedback_gain);
      end
      msvf_pkg::OP_LAD_MUL: begin
        mul_a = (SW+1)'(prev_q) - (SW+1)'(stg_q[cmd_i.stage]);
        mul_b = CW'(cfg_i.stage_gain);
      end
      msvf_pkg::OP_LAD_MAKEUP: begin
        mul_a = (SW+1)'(stg_q[3]);
        mul_b = CW'(cfg_i.makeup_gain);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Sample to state format
  logic signed [XW-1:0] x_ext;
  assign x_ext = ((XW'(sample_in_i) + RndIn) >>> ShNeg) <<< ShPos;

  // Table lookup: index and fraction of |v| scaled by DEPTH/4
  logic        [SW-1:0]      t_abs;
  logic        [SW+Ld-3:0]   t_pos;
  logic        [IdxW-1:0]    t_idx;
  logic                      t_over;
  logic        [Ld:0]        lo_addr;
  logic        [Ld:0]        hi_addr;

  assign t_abs   = t_q[SW-1] ? (~t_q + SW'(1)) : t_q;
  assign t_pos   = {t_abs, {(Ld-2){1'b0}}};
  assign t_idx   = t_pos[SW+Ld-3:Frac];
  assign t_over  = |t_idx[IdxW-1:Ld];
  assign lo_addr = t_over ? (Ld+1)'(TANH_TABLE_DEPTH) : {1'b0, t_idx[Ld-1:0]};
  assign hi_addr = t_over ? (Ld+1)'(TANH_TABLE_DEPTH) : ({1'b0, t_idx[Ld-1:0]} + (Ld+1)'(1));

  // Interpolate, rescale and restore the sign
  logic signed [WW-1:0] interp;
  logic signed [WW-1:0] th_mag;
  assign interp = WW'(signed'({1'b0, lo_q})) + ((WW'(prod_q) + RndF) >>> Frac);
  assign th_mag = interp <<< (Frac - msvf_pkg::TANH_FRAC);

  // Sums of the two-product steps and the output tap of the selected mode
  logic signed [WW-1:0] acc_sum;
  logic signed [YW-1:0] y_svf;
  assign acc_sum = acc_q + WW'(prod_q);

  always_comb begin
    unique case (cfg_i.filter_mode)
      msvf_pkg::MODE_BANDPASS: y_svf = YW'(v1_q);
      msvf_pkg::MODE_HIGHPASS: y_svf = YW'(x_q) - YW'(mk_q) - YW'(v2_q);
      msvf_pkg::MODE_NOTCH:    y_svf = YW'(x_q) - YW'(mk_q);
      default:                 y_svf = YW'(v2_q);
    endcase
  end

  // State to sample format with clamp
  logic signed [FW-1:0]  y_scaled;
  logic signed [SAW-1:0] y_clamped;
  assign y_scaled = ((FW'(y_q) + RndOut) >>> ShPos) <<< ShNeg;
  assign y_clamped = (y_scaled > OutMax) ? OutMax[SAW-1:0] :
                     (y_scaled < OutMin) ? OutMin[SAW-1:0] : y_scaled[SAW-1:0];

  // Filter state: integrators and ladder stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic1_q <= '0;
      ic2_q <= '0;
      for (int i = 0; i < 4; i++) stg_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        msvf_pkg::OP_SVF_N1:
          ic2_q <= sat(WW'(v2_q) + WW'(v2_q) - WW'(ic2_q));
        msvf_pkg::OP_SVF_END:
          ic1_q <= sat(WW'(th_q) + WW'(th_q));
        msvf_pkg::OP_LAD_ACC:
          stg_q[cmd_i.stage] <=
            sat(WW'(stg_q[cmd_i.stage]) + WW'(sat(rnd_coef(WW'(prod_q)))));
        default: ;
      endcase
      // Hold the result word until taken
      if (cmd_i.op == msvf_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      x_q <= SW'(x_ext);
    end
    unique case (cmd_i.op)
      msvf_pkg::OP_SVF_V3: v3_q  <= sat(WW'(x_q) - WW'(ic2_q));
      msvf_pkg::OP_SVF_M2: acc_q <= WW'(prod_q);
      msvf_pkg::OP_SVF_V1: v1_q  <= sat(rnd_coef(acc_sum));
      msvf_pkg::OP_SVF_M4: acc_q <= WW'(prod_q);
      msvf_pkg::OP_SVF_V2: v2_q  <= sat(WW'(ic2_q) + rnd_coef(acc_sum));
      msvf_pkg::OP_SVF_N1: begin
        t_q  <= sat(WW'(v1_q) + WW'(v1_q) - WW'(ic1_q)) >>> 1;
        mk_q <= sat(rnd_coef(WW'(prod_q)));
      end
      msvf_pkg::OP_TANH_LOOK: begin
        lo_q  <= TanhRom[lo_addr];
        hi_q  <= TanhRom[hi_addr];
        fr_q  <= t_pos[Frac-1:0];
        neg_q <= t_q[SW-1];
      end
      msvf_pkg::OP_TANH_DONE: th_q <= neg_q ? SW'(-th_mag) : SW'(th_mag);
      msvf_pkg::OP_SVF_END:   y_q  <= y_svf;
      msvf_pkg::OP_LAD_FBSAT: t_q  <= sat(rnd_coef(WW'(prod_q)));
      msvf_pkg::OP_LAD_IN:    prev_q <= sat(WW'(x_q) - WW'(th_q));
      msvf_pkg::OP_LAD_ACC:
        prev_q <= sat(WW'(stg_q[cmd_i.stage]) + WW'(sat(rnd_coef(WW'(prod_q)))));
      msvf_pkg::OP_LAD_END:   y_q  <= YW'(sat(rnd_coef(WW'(prod_q))));
      msvf_pkg::OP_OUT:       sample_out_q <= y_clamped;
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/multimode_svf_ladder_filter.sv =====
// Top level of the multimode state-variable and ladder audio filter
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  input    | in_valid_i / in_ready_o    | sample_in_i
//  output   | out_valid_o / out_ready_i  | sample_out_o
//  config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each word runs from acceptance to the result register as a sequence
// of products on the single shared multiplier; the sequence is longer in
// ladder mode than in the state-variable modes.
// The result register parts the two sides: the next word is taken while a
// result waits, and the sequence stalls only before its final write.
// Reset clears the integrators, the ladder stages and all control state;
// configuration writes are taken in any cycle.
module multimode_svf_ladder_filter #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int STATE_WIDTH      = 32,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [msvf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [msvf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  msvf_pkg::cfg_t cfg;
  msvf_pkg::cmd_t cmd;
  msvf_pkg::sts_t sts;

  // Registers accept a word in every cycle
  assign cfg_ready_o = 1'b1;

  msvf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  msvf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .filter_mode_i (cfg.filter_mode),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  msvf_dp #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .STATE_WIDTH      (STATE_WIDTH),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .sample_in_i  (sample_in_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .sts_o        (sts)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench of the multimode state-variable and ladder audio filter
`timescale 1ns / 1ps

module tb;

  localparam int SW        = 16;
  localparam int ROM_DEPTH = 256;
  localparam int ST_FRAC   = 24;
  localparam int SHIFT     = ST_FRAC - (SW - 1);
  localparam int LIMIT     = 2000000;

  // Filter predictor with its own state, plus the store of expected samples
  class filter_scoreboard;
    longint       rom[ROM_DEPTH];
    longint       rom_end;
    longint       integ1, integ2;
    longint       stages[4];
    logic [2:0]   mode;
    longint       a1, a2, a3, damp, sgain, fbgain, mkgain;
    logic signed [SW-1:0] pending[$];
    int           errors;

    function new();
      for (int i = 0; i < ROM_DEPTH; i++) rom[i] = tanh_point(i);
      rom_end = tanh_point(ROM_DEPTH);
      integ1 = 0;
      integ2 = 0;
      foreach (stages[i]) stages[i] = 0;
      mode   = msvf_pkg::MODE_LOWPASS;
      a1     = msvf_pkg::RST_COEF_A1;
      a2     = msvf_pkg::RST_COEF_A2;
      a3     = msvf_pkg::RST_COEF_A3;
      damp   = msvf_pkg::RST_DAMPING;
      sgain  = msvf_pkg::RST_STAGE_GAIN;
      fbgain = msvf_pkg::RST_FEEDBACK_GAIN;
      mkgain = msvf_pkg::RST_MAKEUP_GAIN;
      errors = 0;
    endfunction

    function longint rnd_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint sat32(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< 31) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint scale(longint v, longint c);
      return sat32(rnd_shift(v * c, msvf_pkg::COEF_FRAC));
    endfunction

    // Taylor series of exp(-u), squared four times, then (1-e)/(1+e)
    function longint tanh_point(int i);
      longint unsigned one;
      longint unsigned u;
      longint unsigned acc;
      longint unsigned term;
      longint unsigned num;
      longint unsigned den;
      one = 64'd1 << msvf_pkg::EXP_FRAC;
      u = (longint'(i) << msvf_pkg::EXP_FRAC) / (2 * ROM_DEPTH);
      acc = one;
      term = one;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * u) >> msvf_pkg::EXP_FRAC) / n;
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      for (int n = 0; n < 4; n++) acc = (acc * acc + (one >> 1)) >> msvf_pkg::EXP_FRAC;
      if (acc > one) acc = one;
      num = one - acc;
      den = one + acc;
      return longint'(((num << msvf_pkg::TANH_FRAC) + (den >> 1)) / den);
    endfunction

    // Interpolated tanh of a state value, result in state format
    function longint soft_tanh(longint v);
      longint unsigned mag;
      longint unsigned pos;
      longint unsigned idx;
      longint fr;
      longint y;
      longint lo;
      longint hi;
      mag = v < 0 ? -v : v;
      pos = (mag * ROM_DEPTH) >> 2;
      idx = pos >> ST_FRAC;
      fr  = pos & ((64'd1 << ST_FRAC) - 1);
      if (idx >= ROM_DEPTH) begin
        y = rom_end;
      end else begin
        lo = rom[idx];
        hi = (idx + 1 < ROM_DEPTH) ? rom[idx + 1] : rom_end;
        y = lo + rnd_shift((hi - lo) * fr, ST_FRAC);
      end
      y = y <<< (ST_FRAC - msvf_pkg::TANH_FRAC);
      return v < 0 ? -y : y;
    endfunction

    function void write_reg(logic [msvf_pkg::CFG_IDX_W-1:0] idx,
                            logic [msvf_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        msvf_pkg::REG_FILTER_MODE: begin
          mode = d[2:0];
          if (mode > msvf_pkg::MODE_LADDER) mode = msvf_pkg::MODE_LOWPASS;
        end
        msvf_pkg::REG_COEF_A1:       a1 = d[17:0];
        msvf_pkg::REG_COEF_A2:       a2 = d[17:0];
        msvf_pkg::REG_COEF_A3:       a3 = d[17:0];
        msvf_pkg::REG_DAMPING:       damp = d[17:0];
        msvf_pkg::REG_STAGE_GAIN:    sgain = d[15:0];
        msvf_pkg::REG_FEEDBACK_GAIN: fbgain = d[18:0];
        msvf_pkg::REG_MAKEUP_GAIN:   mkgain = d[17:0];
        default: ;
      endcase
    endfunction

    // Advance the filter by one accepted word and hold the expected sample
    function void note_input(logic signed [SW-1:0] s);
      longint x, y, fb, prev, v1, v2, v3, n1, ic1, ic2;
      x = longint'(s) <<< SHIFT;
      if (mode == msvf_pkg::MODE_LADDER) begin
        fb = soft_tanh(scale(stages[3], fbgain));
        prev = sat32(x - fb);
        for (int i = 0; i < 4; i++) begin
          stages[i] = sat32(stages[i] + scale(prev - stages[i], sgain));
          prev = stages[i];
        end
        y = scale(stages[3], mkgain);
      end else begin
        ic1 = integ1;
        ic2 = integ2;
        v3 = sat32(x - ic2);
        v1 = sat32(rnd_shift(a1 * ic1 + a2 * v3, msvf_pkg::COEF_FRAC));
        v2 = sat32(ic2 + rnd_shift(a2 * ic1 + a3 * v3, msvf_pkg::COEF_FRAC));
        n1 = sat32(2 * v1 - ic1);
        integ2 = sat32(2 * v2 - ic2);
        integ1 = sat32(2 * soft_tanh(n1 >>> 1));
        case (mode)
          msvf_pkg::MODE_BANDPASS: y = v1;
          msvf_pkg::MODE_HIGHPASS: y = x - scale(v1, damp) - v2;
          msvf_pkg::MODE_NOTCH:    y = x - scale(v1, damp);
          default:                 y = v2;
        endcase
      end
      y = rnd_shift(y, SHIFT);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      pending.push_back(y[SW-1:0]);
    endfunction

    function void check_output(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                 $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [SW-1:0]              sample_in_i;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [SW-1:0]              sample_out_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [msvf_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [msvf_pkg::CFG_DATA_W-1:0]   cfg_data_i;

  filter_scoreboard sb;
  bit               quiet;
  bit               holdoff_tgl  = 1'b0;
  bit               holdoff_seen = 1'b0;
  int               stall_left   = 0;
  int               cycle_cnt    = 0;

  multimode_svf_ladder_filter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drop the run on a hang
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Check each accepted result word and pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_output(sample_out_o);
    if (holdoff_tgl != holdoff_seen) begin
      holdoff_seen <= holdoff_tgl;
      stall_left   <= 400;
      out_ready_i  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_sample(logic signed [SW-1:0] s);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(s);
  endtask

  task automatic write_cfg(logic [msvf_pkg::CFG_IDX_W-1:0] idx,
                           logic [msvf_pkg::CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  // Hold until every expected sample is back and the pipeline has drained
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [msvf_pkg::CFG_DATA_W-1:0] pick_value(int kind, int width);
    logic [msvf_pkg::CFG_DATA_W-1:0] m;
    m = msvf_pkg::CFG_DATA_W'((32'd1 << width) - 32'd1);
    case (kind)
      0: return '0;
      1: return {msvf_pkg::CFG_DATA_W{1'b1}};
      2: return $urandom_range(0, 1) ? msvf_pkg::CFG_DATA_W'($urandom()) :
                msvf_pkg::CFG_DATA_W'(($urandom() & 32'(m)) >> 2);
      default: return msvf_pkg::CFG_DATA_W'($urandom() & 32'(m));
    endcase
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return SW'($urandom());
      1: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      default: return $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    endcase
  endfunction

  initial begin
    logic signed [SW-1:0] corner[6];
    logic [2:0] m;
    int kind;
    sb          = new();
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = msvf_pkg::REG_FILTER_MODE;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes and values near zero of the sample through every mode at reset coefficients
    corner = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFF};
    for (int md = msvf_pkg::MODE_LOWPASS; md <= msvf_pkg::MODE_LADDER; md++) begin
      write_cfg(msvf_pkg::REG_FILTER_MODE, msvf_pkg::CFG_DATA_W'(md));
      for (int i = 0; i < 4; i++) send_sample(corner[i + (md % 2)]);
      settle();
    end
    // Out-of-range modes fall back to lowpass
    for (int md = 5; md <= 7; md++) begin
      write_cfg(msvf_pkg::REG_FILTER_MODE, {16'h7FFF, 3'(md)});
      send_sample(-16'sh8000);
      settle();
    end

    // Random phases; first two use all-zero and all-ones registers
    for (int ph = 0; ph < 14; ph++) begin
      kind = (ph < 2) ? ph : (ph < 4 ? 1 + ph % 2 : $urandom_range(2, 3));
      if (ph >= 2) kind = (kind == 1) ? 1 : $urandom_range(2, 3);
      m = (ph < 2) ? 3'(ph * 4) : 3'($urandom_range(0, 7));
      if (ph >= 2 && ph < 7) m = 3'(ph - 2);
      write_cfg(msvf_pkg::REG_FILTER_MODE, {16'($urandom_range(0, 65535)), m});
      write_cfg(msvf_pkg::REG_COEF_A1, pick_value(kind, 18));
      write_cfg(msvf_pkg::REG_COEF_A2, pick_value(kind, 18));
      write_cfg(msvf_pkg::REG_COEF_A3, pick_value(kind, 18));
      write_cfg(msvf_pkg::REG_DAMPING, pick_value(kind, 18));
      write_cfg(msvf_pkg::REG_STAGE_GAIN, pick_value(kind, 16));
      write_cfg(msvf_pkg::REG_FEEDBACK_GAIN, pick_value(kind, 19));
      write_cfg(msvf_pkg::REG_MAKEUP_GAIN, pick_value(kind, 18));
      if (ph == 13) quiet = 1'b1;
      for (int i = 0; i < 130; i++) begin
        if (ph == 4 && i == 10) holdoff_tgl <= ~holdoff_tgl;
        send_sample(rand_sample());
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/msvf_pkg.sv
hw/rtl/msvf_cfg.sv
hw/rtl/msvf_ctrl.sv
hw/rtl/msvf_dp.sv
hw/rtl/multimode_svf_ladder_filter.sv
tb/sv/tb.sv
